[rtl/psd3_pkg.sv]
package psd3_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIST_BITS  = 25;

  // difference vectors, one bit wider than a coordinate
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // squared magnitude of a difference, summed over three axes
  localparam int SQ_BITS    = 2 * DIFF_BITS + 2;
  // cross product component magnitude
  localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
  // numerator |u x w|^2 scaled by 2^(2*FRAC_BITS)
  localparam int NUM_BITS   = 2 * CROSS_BITS + 2 + 2 * FRAC_BITS;
  // quotient has at most SQ_BITS-free width; keep full numerator width
  localparam int QUO_BITS   = NUM_BITS;
  // square root width
  localparam int ROOT_BITS  = (NUM_BITS + 1) / 2;

  typedef enum logic [1:0] {
    REGION_FIRST  = 2'd0,
    REGION_SECOND = 2'd1,
    REGION_INNER  = 2'd2
  } region_t;

  // one transaction moving down a chain of cells
  typedef struct packed {
    logic                  valid;
    region_t               region;
    logic [NUM_BITS-1:0]   rem;
    logic [QUO_BITS-1:0]   quo;
    logic [SQ_BITS-1:0]    div;
  } div_tok_t;

  typedef struct packed {
    logic                  valid;
    region_t               region;
    logic [NUM_BITS-1:0]   rad;
    logic [ROOT_BITS-1:0]  root;
    logic [NUM_BITS+1:0]   rem;
  } sqrt_tok_t;

endpackage

[rtl/point_segment_distance_3d_core.sv]
// Point to 3-D segment distance. One query is taken per clock when start is
// high (busy stays low: the core never stalls). Each result appears on
// distance_fixed and nearest_region for exactly one cycle with done high,
// after passing 5 front stages, one cell per quotient bit, one cell per root
// bit and one output register; results leave in issue order. The divider and
// square-root cell chains each produce one bit per cell.
module point_segment_distance_3d_core
  import psd3_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] p_z,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] a_z,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] b_z,
  output logic                         done,
  output logic [DIST_BITS-1:0]         distance_fixed,
  output logic [1:0]                   nearest_region
);

  // fully pipelined, never busy
  assign busy = 1'b0;

  div_tok_t  dchain [QUO_BITS+1];
  sqrt_tok_t rchain [ROOT_BITS+1];

  psd3_front u_front (
    .clk, .rst,
    .in_valid (start),
    .p_x, .p_y, .p_z, .a_x, .a_y, .a_z, .b_x, .b_y, .b_z,
    .tok      (dchain[0])
  );

  // divider cells, msb of the quotient first
  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    psd3_div_cell u_cell (
      .clk, .rst,
      .bit_pos ($clog2(QUO_BITS)'(QUO_BITS - 1 - g)),
      .tok_in  (dchain[g]),
      .tok_out (dchain[g+1])
    );
  end

  // hand quotient to the root chain
  always_comb begin
    rchain[0].valid  = dchain[QUO_BITS].valid;
    rchain[0].region = dchain[QUO_BITS].region;
    rchain[0].rad    = dchain[QUO_BITS].quo;
    rchain[0].rem    = (NUM_BITS+2)'(dchain[QUO_BITS].quo);
    rchain[0].root   = '0;
  end

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
    psd3_sqrt_cell u_cell (
      .clk, .rst,
      .bit_pos ($clog2(ROOT_BITS)'(ROOT_BITS - 1 - g)),
      .tok_in  (rchain[g]),
      .tok_out (rchain[g+1])
    );
  end

  // saturate and register outputs
  logic root_big;

  assign root_big = (rchain[ROOT_BITS].root >> DIST_BITS) != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rchain[ROOT_BITS].valid;
    end
    distance_fixed <= root_big ? {DIST_BITS{1'b1}}
                               : DIST_BITS'(rchain[ROOT_BITS].root);
    nearest_region <= rchain[ROOT_BITS].region;
  end

  // root squared never exceeds the radicand
  a_root_le: assert property (@(posedge clk) disable iff (rst)
    rchain[ROOT_BITS].valid |->
      (2*ROOT_BITS)'(rchain[ROOT_BITS].root) * (2*ROOT_BITS)'(rchain[ROOT_BITS].root)
      <= (2*ROOT_BITS)'(rchain[ROOT_BITS].rad))
    else $error("root too large");

  // remainder below divisor after the last divider cell
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    dchain[QUO_BITS].valid |->
      dchain[QUO_BITS].rem < NUM_BITS'(dchain[QUO_BITS].div))
    else $error("divider remainder out of range");

  // region code is never the unused value
  a_region: assert property (@(posedge clk) disable iff (rst)
    done |-> nearest_region != 2'd3)
    else $error("bad region");

endmodule

[rtl/psd3_front.sv]
module psd3_front
  import psd3_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] p_z,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] a_z,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] b_z,
  output div_tok_t                     tok
);

  localparam int PROD_BITS = 2 * DIFF_BITS;

  // stage 1: differences
  logic                        s1_valid;
  logic signed [DIFF_BITS-1:0] u [3];
  logic signed [DIFF_BITS-1:0] w [3];
  logic signed [DIFF_BITS-1:0] e [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    u[0] <= DIFF_BITS'(b_x) - DIFF_BITS'(a_x);
    u[1] <= DIFF_BITS'(b_y) - DIFF_BITS'(a_y);
    u[2] <= DIFF_BITS'(b_z) - DIFF_BITS'(a_z);
    w[0] <= DIFF_BITS'(a_x) - DIFF_BITS'(p_x);
    w[1] <= DIFF_BITS'(a_y) - DIFF_BITS'(p_y);
    w[2] <= DIFF_BITS'(a_z) - DIFF_BITS'(p_z);
    e[0] <= DIFF_BITS'(b_x) - DIFF_BITS'(p_x);
    e[1] <= DIFF_BITS'(b_y) - DIFF_BITS'(p_y);
    e[2] <= DIFF_BITS'(b_z) - DIFF_BITS'(p_z);
  end

  // stage 2: all products, one multiplier each
  logic                        s2_valid;
  logic signed [PROD_BITS-1:0] uu [3];
  logic signed [PROD_BITS-1:0] uw [3];
  logic signed [PROD_BITS-1:0] ww [3];
  logic signed [PROD_BITS-1:0] ee [3];
  logic signed [PROD_BITS-1:0] xp [3];
  logic signed [PROD_BITS-1:0] xn [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    for (int i = 0; i < 3; i++) begin
      uu[i] <= PROD_BITS'(u[i] * u[i]);
      uw[i] <= PROD_BITS'(u[i] * w[i]);
      ww[i] <= PROD_BITS'(w[i] * w[i]);
      ee[i] <= PROD_BITS'(e[i] * e[i]);
    end
    xp[0] <= PROD_BITS'(u[1] * w[2]);
    xn[0] <= PROD_BITS'(u[2] * w[1]);
    xp[1] <= PROD_BITS'(u[2] * w[0]);
    xn[1] <= PROD_BITS'(u[0] * w[2]);
    xp[2] <= PROD_BITS'(u[0] * w[1]);
    xn[2] <= PROD_BITS'(u[1] * w[0]);
  end

  // stage 3: sums and cross components
  logic                         s3_valid;
  logic        [SQ_BITS-1:0]    sa;
  logic signed [SQ_BITS-1:0]    sb;
  logic        [SQ_BITS-1:0]    sc;
  logic        [SQ_BITS-1:0]    se;
  logic        [CROSS_BITS-1:0] xm [3];
  logic signed [CROSS_BITS-1:0] xs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = CROSS_BITS'(xp[i]) - CROSS_BITS'(xn[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    sa <= SQ_BITS'(uu[0]) + SQ_BITS'(uu[1]) + SQ_BITS'(uu[2]);
    sb <= SQ_BITS'(uw[0]) + SQ_BITS'(uw[1]) + SQ_BITS'(uw[2]);
    sc <= SQ_BITS'(ww[0]) + SQ_BITS'(ww[1]) + SQ_BITS'(ww[2]);
    se <= SQ_BITS'(ee[0]) + SQ_BITS'(ee[1]) + SQ_BITS'(ee[2]);
    for (int i = 0; i < 3; i++) begin
      xm[i] <= xs[i][CROSS_BITS-1] ? CROSS_BITS'(-xs[i]) : xs[i];
    end
  end

  // stage 4: squares of cross magnitudes, region decision
  logic                          s4_valid;
  region_t                       s4_region;
  logic [SQ_BITS-1:0]            s4_sq;
  logic [SQ_BITS-1:0]            s4_sa;
  logic [2*CROSS_BITS-1:0]       xq [3];
  logic signed [SQ_BITS:0]       sum_ab;

  assign sum_ab = (SQ_BITS+1)'(sb) + (SQ_BITS+1)'(sa);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    for (int i = 0; i < 3; i++) begin
      xq[i] <= xm[i] * xm[i];
    end
    s4_sa <= sa;
    if (sa == '0 || !sb[SQ_BITS-1]) begin
      s4_region <= REGION_FIRST;
      s4_sq     <= sc;
    end else if (sum_ab[SQ_BITS] || sum_ab == '0) begin
      s4_region <= REGION_SECOND;
      s4_sq     <= se;
    end else begin
      s4_region <= REGION_INNER;
      s4_sq     <= '0;
    end
  end

  // stage 5: scaled numerator for the divider chain
  logic [NUM_BITS-1:0] xsum;

  assign xsum = NUM_BITS'(xq[0]) + NUM_BITS'(xq[1]) + NUM_BITS'(xq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= s4_valid;
    end
    tok.region <= s4_region;
    tok.quo    <= '0;
    if (s4_region == REGION_INNER) begin
      tok.rem <= xsum << (2 * FRAC_BITS);
      tok.div <= s4_sa;
    end else begin
      // endpoint cases pass through the divider as a divide by one
      tok.rem <= NUM_BITS'(s4_sq) << (2 * FRAC_BITS);
      tok.div <= SQ_BITS'(1);
    end
  end

endmodule

[rtl/psd3_div_cell.sv]
module psd3_div_cell
  import psd3_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic [$clog2(QUO_BITS)-1:0] bit_pos,
  input  div_tok_t tok_in,
  output div_tok_t tok_out
);

  // restoring step on one quotient bit; partial remainder stays in rem
  logic [NUM_BITS+SQ_BITS-1:0] trial;
  logic                        take;

  assign trial = (NUM_BITS+SQ_BITS)'(tok_in.div) << bit_pos;
  assign take  = (NUM_BITS+SQ_BITS)'(tok_in.rem) >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.region <= tok_in.region;
    tok_out.div    <= tok_in.div;
    tok_out.rem    <= take ? NUM_BITS'((NUM_BITS+SQ_BITS)'(tok_in.rem) - trial)
                           : tok_in.rem;
    tok_out.quo    <= tok_in.quo | (QUO_BITS'(take) << bit_pos);
  end

endmodule

[rtl/psd3_sqrt_cell.sv]
module psd3_sqrt_cell
  import psd3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic [$clog2(ROOT_BITS)-1:0] bit_pos,
  input  sqrt_tok_t tok_in,
  output sqrt_tok_t tok_out
);

  // one root bit: test (2r + 2^b) * 2^b against the remaining radicand
  logic [NUM_BITS+1:0] trial;
  logic                take;

  assign trial = ((NUM_BITS+2)'(tok_in.root) << (bit_pos + 1'b1))
               + ((NUM_BITS+2)'(1) << (2 * bit_pos));
  assign take  = tok_in.rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.region <= tok_in.region;
    tok_out.rad    <= tok_in.rad;
    tok_out.rem    <= take ? tok_in.rem - trial : tok_in.rem;
    tok_out.root   <= tok_in.root | (ROOT_BITS'(take) << bit_pos);
  end

endmodule

[bench/testbench.sv]
module testbench;
  import psd3_pkg::*;

  // one query: point, first endpoint, second endpoint
  typedef struct {
    logic signed [COORD_BITS-1:0] px, py, pz, ax, ay, az, bx, by, bz;
  } query_t;

  typedef struct {
    logic [DIST_BITS-1:0] distance;
    logic [1:0]           region;
  } answer_t;

  // depth of the core pipeline: front stages, divider cells, root cells, output register
  localparam int PIPE_DEPTH = 5 + QUO_BITS + ROOT_BITS + 1;
  localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_BITS-1:0] p_x = '0, p_y = '0, p_z = '0;
  logic signed [COORD_BITS-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [COORD_BITS-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic done;
  logic [DIST_BITS-1:0] distance_fixed;
  logic [1:0] nearest_region;

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  int      error_count = 0;
  int      answers_seen = 0;
  int      region_hits[3] = '{0, 0, 0};
  bit      hold_sender = 1'b0;
  bit      no_idle = 1'b0;

  always #1 clk = ~clk;

  point_segment_distance_3d_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .p_x(p_x), .p_y(p_y), .p_z(p_z),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .done(done), .distance_fixed(distance_fixed), .nearest_region(nearest_region)
  );

  // integer square root of a wide value, bit by bit from the top
  function automatic logic [63:0] isqrt_wide(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // exact nearest-point distance, scaled by 2^FRAC_BITS, truncated and saturated
  function automatic answer_t segment_distance(query_t q);
    longint u[3], w[3], e[3], cr[3];
    longint sa, sb;
    logic [127:0] num;
    logic [63:0]  root;
    answer_t      ans;
    u[0] = longint'(q.bx) - longint'(q.ax);
    u[1] = longint'(q.by) - longint'(q.ay);
    u[2] = longint'(q.bz) - longint'(q.az);
    w[0] = longint'(q.ax) - longint'(q.px);
    w[1] = longint'(q.ay) - longint'(q.py);
    w[2] = longint'(q.az) - longint'(q.pz);
    e[0] = longint'(q.bx) - longint'(q.px);
    e[1] = longint'(q.by) - longint'(q.py);
    e[2] = longint'(q.bz) - longint'(q.pz);
    sa = 0;
    sb = 0;
    num = '0;
    for (int i = 0; i < 3; i++) begin
      sa += u[i] * u[i];
      sb += u[i] * w[i];
    end
    if (sa == 0 || sb >= 0) begin
      ans.region = REGION_FIRST;
      for (int i = 0; i < 3; i++) num += 128'(w[i] * w[i]);
      num = num << (2 * FRAC_BITS);
    end else if (-sb >= sa) begin
      ans.region = REGION_SECOND;
      for (int i = 0; i < 3; i++) num += 128'(e[i] * e[i]);
      num = num << (2 * FRAC_BITS);
    end else begin
      ans.region = REGION_INNER;
      cr[0] = u[1] * w[2] - u[2] * w[1];
      cr[1] = u[2] * w[0] - u[0] * w[2];
      cr[2] = u[0] * w[1] - u[1] * w[0];
      // each component magnitude stays below 2^35, so squares fit in 128 bits
      for (int i = 0; i < 3; i++) begin
        logic [127:0] m;
        m = cr[i] < 0 ? 128'(-cr[i]) : 128'(cr[i]);
        num += m * m;
      end
      num = (num << (2 * FRAC_BITS)) / 128'(sa);
    end
    root = isqrt_wide(num);
    ans.distance = (root > 64'((1 << DIST_BITS) - 1)) ? '1 : root[DIST_BITS-1:0];
    return ans;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom);
  endfunction

  function automatic query_t random_query();
    query_t q;
    int unsigned mode;
    int span;
    mode = $urandom_range(0, 9);
    q.px = rand_coord(); q.py = rand_coord(); q.pz = rand_coord();
    q.ax = rand_coord(); q.ay = rand_coord(); q.az = rand_coord();
    q.bx = rand_coord(); q.by = rand_coord(); q.bz = rand_coord();
    if (mode < 3) begin
      // small cluster around the first endpoint, stresses ties and short segments
      span = $urandom_range(1, 8);
      q.bx = q.ax + $signed($urandom_range(0, 2 * span)) - span;
      q.by = q.ay + $signed($urandom_range(0, 2 * span)) - span;
      q.bz = q.az + $signed($urandom_range(0, 2 * span)) - span;
      q.px = q.ax + $signed($urandom_range(0, 4 * span)) - 2 * span;
      q.py = q.ay + $signed($urandom_range(0, 4 * span)) - 2 * span;
      q.pz = q.az + $signed($urandom_range(0, 4 * span)) - 2 * span;
    end else if (mode == 3) begin
      // degenerate segment
      q.bx = q.ax; q.by = q.ay; q.bz = q.az;
    end else if (mode == 4) begin
      // point on the segment line, midpoint style
      q.px = (q.ax >>> 1) + (q.bx >>> 1);
      q.py = (q.ay >>> 1) + (q.by >>> 1);
      q.pz = (q.az >>> 1) + (q.bz >>> 1);
    end
    return q;
  endfunction

  function automatic query_t make_query(int px, int py, int pz, int ax, int ay, int az,
                                        int bx, int by, int bz);
    query_t q;
    q.px = px; q.py = py; q.pz = pz;
    q.ax = ax; q.ay = ay; q.az = az;
    q.bx = bx; q.by = by; q.bz = bz;
    return q;
  endfunction

  // driver: one transaction per accepted start, random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_answers.push_back(segment_distance(make_query(p_x, p_y, p_z,
            a_x, a_y, a_z, b_x, b_y, b_z)));
      end
      if (!(start && busy)) begin
        if (pending_queries.size() > 0 && !hold_sender &&
            (no_idle || $urandom_range(0, 99) >= 29)) begin
          query_t q;
          q = pending_queries.pop_front();
          start <= 1'b1;
          p_x <= q.px; p_y <= q.py; p_z <= q.pz;
          a_x <= q.ax; a_y <= q.ay; a_z <= q.az;
          b_x <= q.bx; b_y <= q.by; b_z <= q.bz;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is compared with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result distance=%0d region=%0d", $time,
                 distance_fixed, nearest_region);
        error_count++;
      end else begin
        answer_t exp_ans;
        exp_ans = expected_answers.pop_front();
        answers_seen++;
        if (nearest_region < 3) region_hits[nearest_region]++;
        if (distance_fixed !== exp_ans.distance) begin
          $display("%0t: distance mismatch expected %0d actual %0d", $time,
                   exp_ans.distance, distance_fixed);
          error_count++;
        end
        if (nearest_region !== exp_ans.region) begin
          $display("%0t: region mismatch expected %0d actual %0d", $time,
                   exp_ans.region, nearest_region);
          error_count++;
        end
      end
    end
  end

  // stimulus: directed corners first, then random traffic in phases
  initial begin
    // point at endpoints, exact ties, interior foot
    pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(5, 0, 0, 0, 0, 0, 10, 0, 0));
    pending_queries.push_back(make_query(5, 7, 0, 0, 0, 0, 10, 0, 0));
    pending_queries.push_back(make_query(-3, 1, 0, 0, 0, 0, 10, 0, 0));
    pending_queries.push_back(make_query(13, 1, 2, 0, 0, 0, 10, 0, 0));
    pending_queries.push_back(make_query(0, 9, 0, 0, 0, 0, 10, 0, 0));
    pending_queries.push_back(make_query(10, 9, 0, 0, 0, 0, 10, 0, 0));
    pending_queries.push_back(make_query(1, 1, 1, 0, 0, 0, 3, 3, 3));
    pending_queries.push_back(make_query(4, 5, 6, 4, 5, 6, 4, 5, 6));
    pending_queries.push_back(make_query(1, 2, 3, -7, 8, 9, -7, 8, 9));
    // extreme coordinates
    pending_queries.push_back(make_query(COORD_MAX, COORD_MAX, COORD_MAX,
        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    pending_queries.push_back(make_query(COORD_MIN, COORD_MIN, COORD_MIN,
        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    pending_queries.push_back(make_query(COORD_MAX, COORD_MIN, COORD_MAX,
        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    pending_queries.push_back(make_query(COORD_MAX, COORD_MIN, 0,
        COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    pending_queries.push_back(make_query(COORD_MIN, COORD_MAX, COORD_MIN,
        COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    pending_queries.push_back(make_query(0, COORD_MAX, 0,
        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    pending_queries.push_back(make_query(-1, -1, -1, 0, 0, 0, -2, -2, -2));
    pending_queries.push_back(make_query(COORD_MIN, 0, 0, COORD_MAX, 0, 0, COORD_MAX, 0, 1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 350; i++) pending_queries.push_back(random_query());
    wait (pending_queries.size() == 0);
    // let everything in flight drain before the next phase
    hold_sender = 1'b1;
    wait (expected_answers.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;
    no_idle = 1'b1;
    for (int i = 0; i < 300; i++) pending_queries.push_back(random_query());
    wait (pending_queries.size() == 0);
    no_idle = 1'b0;
    for (int i = 0; i < 350; i++) pending_queries.push_back(random_query());
    wait (pending_queries.size() == 0);
    @(posedge clk);
    wait (expected_answers.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    $display("checked %0d results: %0d first endpoint, %0d second endpoint, %0d interior",
             answers_seen, region_hits[0], region_hits[1], region_hits[2]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
